/* rtl/cnpm_pkg.sv */
// cnpm_pkg: widths, register indexes, status codes and cbor constants for the
// nested path map encoder. no dependencies; used by cnpm_if.sv and the top level.
package cnpm_pkg;

  // path shape
  localparam int MAX_DEPTH = 4;
  localparam int NUM_IDS   = 4;
  localparam int MIN_LEN   = 3;   // resource level
  localparam int ID_W      = 16;
  localparam int LEN_W     = 3;
  localparam int SEL_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int CNT_W     = 16;

  // most beats one path may produce, and the width of the beat counter
  localparam int MAX_RESULTS = 22;
  localparam int RUN_W       = 5;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_ITEMS = 2'd1,
    ST_BAD_PATH = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_LEN   = 3'd0,
    REG_BASE_ID_0  = 3'd1,
    REG_BASE_ID_1  = 3'd2,
    REG_BASE_ID_2  = 3'd3,
    REG_BASE_ID_3  = 3'd4,
    REG_ITEM_TOTAL = 3'd5
  } reg_idx_t;

  localparam logic KIND_PATH  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  // cbor initial bytes
  localparam byte_t CBOR_MAP_OPEN = 8'hBF;
  localparam byte_t CBOR_BREAK    = 8'hFF;
  localparam byte_t CBOR_UINT8    = 8'h18;
  localparam byte_t CBOR_UINT16   = 8'h19;
  localparam id_t   CBOR_IMM_LIM  = 16'd24;
  localparam id_t   CBOR_U8_LIM   = 16'd256;

endpackage

/* rtl/cnpm_if.sv */
// cnpm_if: valid/ready channel interfaces for config writes, input paths and
// encoded bytes. depends on cnpm_pkg.
interface cnpm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cnpm_pkg::CFG_IDX_W-1:0] idx;
  logic [cnpm_pkg::CFG_DAT_W-1:0] wdata;
  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

interface cnpm_path_if;
  logic                       valid;
  logic                       ready;
  logic [cnpm_pkg::LEN_W-1:0] path_len;
  logic [cnpm_pkg::ID_W-1:0]  id_0;
  logic [cnpm_pkg::ID_W-1:0]  id_1;
  logic [cnpm_pkg::ID_W-1:0]  id_2;
  logic [cnpm_pkg::ID_W-1:0]  id_3;
  modport source (output valid, path_len, id_0, id_1, id_2, id_3, input ready);
  modport sink   (input valid, path_len, id_0, id_1, id_2, id_3, output ready);
endinterface

interface cnpm_byte_if;
  logic                        valid;
  logic                        ready;
  logic [cnpm_pkg::BYTE_W-1:0] out_byte;
  logic                        byte_kind;
  logic [cnpm_pkg::ST_W-1:0]   status;
  logic                        last_of_run;
  modport source (output valid, out_byte, byte_kind, status, last_of_run, input ready);
  modport sink   (input valid, out_byte, byte_kind, status, last_of_run, output ready);
endinterface

/* rtl/cbor_nested_path_map_encoder.sv */
// cbor_nested_path_map_encoder: turns resource paths into nested cbor map bytes
// with a small sequencer around one shared id comparator. depends on cnpm_pkg, cnpm_if.
//
//  channel    role    beat contents
//  cfg        sink    idx, wdata (register write)
//  path_in    sink    path_len, id_0..id_3 (one resource path)
//  byte_out   source  out_byte, byte_kind, status, last_of_run (one encoded byte)
//
// span is the common prefix with the previous path; the shared comparator walks the
// base and prefix ids one per cycle and the byte sequencer emits one byte per cycle
// while byte_out does not stall
// rejected paths give one status beat
// a run is capped at 22 beats; past that the sequencer walks on without emitting
// rst is synchronous; it clears config, path history and the output register
// a stall on byte_out holds the sequencer while a byte is pending; path_in is ready only
// between paths, while the last byte may still wait in the output register
module cbor_nested_path_map_encoder (
  input  logic                 clk,
  input  logic                 rst,
  cnpm_cfg_if.sink             cfg,
  cnpm_path_if.sink            path_in,
  cnpm_byte_if.source          byte_out
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_BASE, S_SPAN, S_ERR, S_HEAD, S_BRK, S_OPEN,
    S_UINT0, S_UINT1, S_UINT2, S_UPD, S_FIN, S_END
  } state_t;

  state_t state;

  // configuration
  cnpm_pkg::len_t base_len;
  cnpm_pkg::id_t  base_ids [cnpm_pkg::NUM_IDS];

  // message history
  cnpm_pkg::id_t                  prev_ids [cnpm_pkg::NUM_IDS];
  cnpm_pkg::len_t                 prev_len;
  cnpm_pkg::len_t                 open_maps;
  logic [cnpm_pkg::CNT_W-1:0]     items_left;
  logic                           first_entry;

  // current path
  cnpm_pkg::len_t len_r;
  cnpm_pkg::id_t  ids [cnpm_pkg::NUM_IDS];

  // sequencer registers
  cnpm_pkg::len_t    idx;
  cnpm_pkg::len_t    span;
  cnpm_pkg::len_t    lvl;
  cnpm_pkg::len_t    cnt;
  cnpm_pkg::status_t err_code;
  logic [cnpm_pkg::RUN_W-1:0] run_cnt;

  // pending byte: held back in its own register so the last byte of a run can be flagged
  logic            pend_vld;
  cnpm_pkg::byte_t pend_byte;
  logic            pend_kind;

  // output register
  logic                         out_vld;
  cnpm_pkg::byte_t              obyte;
  logic                         okind;
  logic [cnpm_pkg::ST_W-1:0]    ostatus;
  logic                         olast;

  // combinational
  cnpm_pkg::id_t   cmp_a, cmp_b, cur_id;
  logic            cmp_eq;
  cnpm_pkg::len_t  minlen, brk, lvl_inc;
  logic            want, can_out, put_ok, do_put, run_full;
  cnpm_pkg::byte_t put_byte;
  logic            put_kind;
  logic            ld_out;
  cnpm_pkg::byte_t ld_byte;
  logic            ld_kind;
  logic [cnpm_pkg::ST_W-1:0] ld_status;
  logic            ld_last;

  assign cfg.ready      = 1'b1;
  assign path_in.ready  = (state == S_IDLE);
  assign byte_out.valid       = out_vld;
  assign byte_out.out_byte    = obyte;
  assign byte_out.byte_kind   = okind;
  assign byte_out.status      = ostatus;
  assign byte_out.last_of_run = olast;

  // shared comparator: base ids while checking the base path, history otherwise
  assign cmp_a  = ids[idx[cnpm_pkg::SEL_W-1:0]];
  assign cmp_b  = (state == S_BASE) ? base_ids[idx[cnpm_pkg::SEL_W-1:0]]
                                    : prev_ids[idx[cnpm_pkg::SEL_W-1:0]];
  assign cmp_eq = (cmp_a == cmp_b);

  assign cur_id  = ids[lvl[cnpm_pkg::SEL_W-1:0]];
  assign minlen  = (len_r < prev_len) ? len_r : prev_len;
  assign brk     = (prev_len != '0) ? (prev_len - span - 3'd1) : '0;
  assign lvl_inc = lvl + 3'd1;
  assign can_out = !out_vld || byte_out.ready;
  // once the run is full, bytes are dropped and the byte states no longer wait
  assign run_full = (run_cnt == cnpm_pkg::RUN_W'(cnpm_pkg::MAX_RESULTS));
  assign put_ok   = !pend_vld || can_out || run_full;

  // byte the sequencer wants to emit in this state
  always_comb begin
    want     = 1'b0;
    put_byte = cnpm_pkg::CBOR_BREAK;
    put_kind = cnpm_pkg::KIND_PATH;
    unique case (state)
      S_HEAD: begin
        want     = first_entry;
        put_byte = cnpm_pkg::CBOR_MAP_OPEN;
      end
      S_BRK: begin
        want = (cnt != '0);
      end
      S_OPEN: begin
        want     = (lvl != span);
        put_byte = cnpm_pkg::CBOR_MAP_OPEN;
      end
      S_UINT0: begin
        want = 1'b1;
        if (cur_id < cnpm_pkg::CBOR_IMM_LIM) begin
          put_byte = cur_id[cnpm_pkg::BYTE_W-1:0];
        end else if (cur_id < cnpm_pkg::CBOR_U8_LIM) begin
          put_byte = cnpm_pkg::CBOR_UINT8;
        end else begin
          put_byte = cnpm_pkg::CBOR_UINT16;
        end
      end
      S_UINT1: begin
        want     = 1'b1;
        put_byte = (cur_id < cnpm_pkg::CBOR_U8_LIM) ? cur_id[7:0] : cur_id[15:8];
      end
      S_UINT2: begin
        want     = 1'b1;
        put_byte = cur_id[7:0];
      end
      S_FIN: begin
        want     = (open_maps != '0);
        put_kind = cnpm_pkg::KIND_CLOSE;
      end
      default: begin
        want = 1'b0;
      end
    endcase
  end

  assign do_put = want && put_ok && !run_full;

  // output register load: pushed pending byte, final flush or error beat
  always_comb begin
    ld_out    = 1'b0;
    ld_byte   = pend_byte;
    ld_kind   = pend_kind;
    ld_status = cnpm_pkg::ST_OK;
    ld_last   = 1'b0;
    priority if (do_put && pend_vld) begin
      ld_out = 1'b1;
    end else if (state == S_END && pend_vld && can_out) begin
      ld_out  = 1'b1;
      ld_last = 1'b1;
    end else if (state == S_ERR && can_out) begin
      ld_out    = 1'b1;
      ld_byte   = '0;
      ld_kind   = cnpm_pkg::KIND_PATH;
      ld_status = err_code;
      ld_last   = 1'b1;
    end else begin
      ld_out = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      base_len    <= '0;
      for (int i = 0; i < cnpm_pkg::NUM_IDS; i++) begin
        base_ids[i] <= '0;
        prev_ids[i] <= '0;
      end
      prev_len    <= '0;
      open_maps   <= 3'd1;
      items_left  <= '0;
      first_entry <= 1'b1;
      run_cnt     <= '0;
      pend_vld    <= 1'b0;
      out_vld     <= 1'b0;
    end else begin
      // config writes must arrive only between paths; the block itself does not enforce it
      if (cfg.valid) begin
        unique case (cfg.idx)
          cnpm_pkg::REG_BASE_LEN:  base_len    <= cfg.wdata[cnpm_pkg::LEN_W-1:0];
          cnpm_pkg::REG_BASE_ID_0: base_ids[0] <= cfg.wdata;
          cnpm_pkg::REG_BASE_ID_1: base_ids[1] <= cfg.wdata;
          cnpm_pkg::REG_BASE_ID_2: base_ids[2] <= cfg.wdata;
          cnpm_pkg::REG_BASE_ID_3: base_ids[3] <= cfg.wdata;
          cnpm_pkg::REG_ITEM_TOTAL: begin
            // new message
            for (int i = 0; i < cnpm_pkg::NUM_IDS; i++) begin
              prev_ids[i] <= '0;
            end
            prev_len    <= '0;
            open_maps   <= 3'd1;
            items_left  <= cfg.wdata;
            first_entry <= 1'b1;
          end
          default: begin
          end
        endcase
      end

      // output register
      if (ld_out) begin
        out_vld <= 1'b1;
        obyte   <= ld_byte;
        okind   <= ld_kind;
        ostatus <= ld_status;
        olast   <= ld_last;
      end else if (byte_out.ready) begin
        out_vld <= 1'b0;
      end

      // pending byte
      if (do_put) begin
        pend_vld  <= 1'b1;
        pend_byte <= put_byte;
        pend_kind <= put_kind;
        run_cnt   <= run_cnt + 5'd1;
      end else if (state == S_END && can_out) begin
        pend_vld <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (path_in.valid) begin
            len_r   <= path_in.path_len;
            ids[0]  <= path_in.id_0;
            ids[1]  <= path_in.id_1;
            ids[2]  <= path_in.id_2;
            ids[3]  <= path_in.id_3;
            run_cnt <= '0;
            state   <= S_CHK;
          end
        end
        S_CHK: begin
          idx <= '0;
          if (items_left == '0) begin
            err_code <= cnpm_pkg::ST_NO_ITEMS;
            state    <= S_ERR;
          end else if (len_r > cnpm_pkg::LEN_W'(cnpm_pkg::MAX_DEPTH) ||
                       len_r < cnpm_pkg::LEN_W'(cnpm_pkg::MIN_LEN) ||
                       len_r < base_len) begin
            err_code <= cnpm_pkg::ST_BAD_PATH;
            state    <= S_ERR;
          end else begin
            state <= S_BASE;
          end
        end
        S_BASE: begin
          // one base id per cycle
          if (idx < base_len) begin
            if (!cmp_eq) begin
              err_code <= cnpm_pkg::ST_BAD_PATH;
              state    <= S_ERR;
            end else begin
              idx <= idx + 3'd1;
            end
          end else begin
            idx   <= '0;
            state <= S_SPAN;
          end
        end
        S_SPAN: begin
          // common prefix with the previous path, one id per cycle
          if (idx < minlen && cmp_eq) begin
            idx <= idx + 3'd1;
          end else begin
            span <= idx;
            if (prev_len != '0 && idx == prev_len) begin
              err_code <= cnpm_pkg::ST_BAD_PATH;
              state    <= S_ERR;
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_ERR: begin
          if (can_out) begin
            state <= S_IDLE;
          end
        end
        S_HEAD: begin
          if (!want || put_ok) begin
            cnt   <= brk;
            state <= S_BRK;
          end
        end
        S_BRK: begin
          // close maps the new path leaves
          if (cnt != '0) begin
            if (put_ok) begin
              cnt       <= cnt - 3'd1;
              open_maps <= open_maps - 3'd1;
            end
          end else begin
            lvl   <= span;
            state <= (span < len_r) ? S_OPEN : S_UPD;
          end
        end
        S_OPEN: begin
          if (lvl == span) begin
            state <= S_UINT0;
          end else if (put_ok) begin
            open_maps <= open_maps + 3'd1;
            state     <= S_UINT0;
          end
        end
        S_UINT0: begin
          if (put_ok) begin
            if (cur_id < cnpm_pkg::CBOR_IMM_LIM) begin
              lvl   <= lvl_inc;
              state <= (lvl_inc == len_r) ? S_UPD : S_OPEN;
            end else begin
              state <= S_UINT1;
            end
          end
        end
        S_UINT1: begin
          if (put_ok) begin
            if (cur_id < cnpm_pkg::CBOR_U8_LIM) begin
              lvl   <= lvl_inc;
              state <= (lvl_inc == len_r) ? S_UPD : S_OPEN;
            end else begin
              state <= S_UINT2;
            end
          end
        end
        S_UINT2: begin
          if (put_ok) begin
            lvl   <= lvl_inc;
            state <= (lvl_inc == len_r) ? S_UPD : S_OPEN;
          end
        end
        S_UPD: begin
          for (int i = 0; i < cnpm_pkg::NUM_IDS; i++) begin
            prev_ids[i] <= (cnpm_pkg::LEN_W'(i) < len_r) ? ids[i] : '0;
          end
          prev_len    <= len_r;
          first_entry <= 1'b0;
          items_left  <= items_left - 16'd1;
          state       <= (items_left == 16'd1) ? S_FIN : S_END;
        end
        S_FIN: begin
          // last counted path: close everything still open
          if (open_maps != '0) begin
            if (put_ok) begin
              open_maps <= open_maps - 3'd1;
            end
          end else begin
            state <= S_END;
          end
        end
        S_END: begin
          if (!pend_vld || can_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // error beats are always single-beat runs
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    byte_out.valid && byte_out.status != cnpm_pkg::ST_OK |-> byte_out.last_of_run)
    else $error("error beat without last_of_run");

  // closing breaks only on good beats
  a_close_ok: assert property (@(posedge clk) disable iff (rst)
    byte_out.valid && byte_out.byte_kind == cnpm_pkg::KIND_CLOSE
      |-> byte_out.status == cnpm_pkg::ST_OK)
    else $error("closing break with error status");

  // no byte is left behind when the sequencer goes back to wait for a path
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_vld)
    else $error("pending byte lost at end of run");

  // an accepted path blocks the input until its run is done
  a_busy: assert property (@(posedge clk) disable iff (rst)
    path_in.valid && path_in.ready |=> !path_in.ready)
    else $error("input taken while a path is in flight");

endmodule
